// ===== rtl/lzss_pkg.sv =====
// Shared types and constants for the LZSS stream decompressor.
// No dependencies; imported by the top, controller and datapath modules.
`timescale 1ns / 1ps

package lzss_pkg;

  // Ring window geometry (power of two)
  localparam int unsigned WinSize   = 4096;
  localparam int unsigned WinAddrW  = $clog2(WinSize);
  localparam int unsigned FillW     = WinAddrW + 1;
  localparam int unsigned MaxMatch  = 18;
  localparam int unsigned Threshold = 2;
  localparam int unsigned LenW      = $clog2(MaxMatch + 1);
  localparam int unsigned PosW      = 12;

  localparam logic [WinAddrW-1:0] StartIndex = WinAddrW'(WinSize - MaxMatch);
  localparam logic [7:0]          SpaceChar  = 8'h20;
  localparam logic [8:0]          FlagMarker = 9'h100;

  localparam int unsigned CountW   = 32;
  localparam int unsigned OutDataW = 48;

  // Input item kind, carried on tuser
  typedef enum logic [1:0] {
    CmdStart  = 2'd0,
    CmdData   = 2'd1,
    CmdFinish = 2'd2
  } lzss_cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StLit,
    StSum,
    StRd,
    StWr
  } lzss_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic start;
    logic latch_byte;
    logic load_flags;
    logic hold_first;
    logic load_match;
    logic set_ovf;
    logic shift_flag;
    logic end_match;
    logic rd_en;
    logic emit_lit;
    logic emit_copy;
    logic emit_sum;
  } lzss_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic flag_empty;
    logic lit_flag;
    logic expect_second;
    logic ovf;
    logic at_limit;
    logic rem_one;
    logic out_free;
  } lzss_status_t;

endpackage

// ===== rtl/lzss_stream_decompressor.sv =====
// LZSS stream decompressor, 4 KiB ring window, matches of 3 to 18 bytes.
// Flag, start and match-first bytes are taken in idle; a literal or a finish
// summary passes through its own state; a match then steps through a read
// and a write-back of the window RAM for each copied byte.
// Reset clears stream state and sets out_limit to all ones; unwritten window
// entries read as spaces through a fill count, so no clearing pass is needed.
`timescale 1ns / 1ps

module lzss_stream_decompressor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] in_byte
  input  logic [1:0]                  s_axis_tuser,  // [1:0] command
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] out_byte, [39:8] total_bytes, [40] overflow, [47:41] zero
  output logic [lzss_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                        m_axis_tlast,  // run_last
  output logic                        m_axis_tuser,  // [0] is_summary
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lzss_pkg::CountW-1:0] cfg_data_i     // out_limit
);
  import lzss_pkg::*;

  lzss_ctrl_t   ctrl;
  lzss_status_t status;

  assign cfg_ready_o = 1'b1;

  lzss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_cmd_i  (s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .ctrl_o    (ctrl)
  );

  lzss_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (s_axis_tdata),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast),
    .out_user_o (m_axis_tuser)
  );

endmodule

// ===== rtl/lzss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lzss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lzss_ctrl.sv =====
// Token-level controller for the LZSS decompressor.
// Depends on lzss_pkg; drives the datapath through lzss_ctrl_t.
`timescale 1ns / 1ps

module lzss_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_cmd_i,
  output logic                  in_ready_o,
  input  lzss_pkg::lzss_status_t status_i,
  output lzss_pkg::lzss_ctrl_t   ctrl_o
);
  import lzss_pkg::*;

  lzss_state_e state_q, state_d;
  lzss_cmd_e   cmd;

  assign cmd        = lzss_cmd_e'(in_cmd_i);
  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          case (cmd)
            CmdFinish: state_d = StSum;
            CmdData: begin
              if (!status_i.ovf && !status_i.flag_empty) begin
                if (status_i.lit_flag) begin
                  state_d = StLit;
                end else if (status_i.expect_second) begin
                  state_d = StRd;
                end
              end
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StLit: begin
        if (status_i.at_limit || status_i.out_free) begin
          state_d = StIdle;
        end
      end
      StSum: begin
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      StRd: begin
        state_d = status_i.at_limit ? StIdle : StWr;
      end
      StWr: begin
        if (status_i.out_free) begin
          state_d = status_i.rem_one ? StIdle : StRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ctrl_o.latch_byte = 1'b1;
          case (cmd)
            CmdStart: ctrl_o.start = 1'b1;
            CmdData: begin
              if (!status_i.ovf) begin
                if (status_i.flag_empty) begin
                  ctrl_o.load_flags = 1'b1;
                end else if (!status_i.lit_flag) begin
                  if (status_i.expect_second) begin
                    ctrl_o.load_match = 1'b1;
                  end else begin
                    ctrl_o.hold_first = 1'b1;
                  end
                end
              end
            end
            default: ctrl_o.latch_byte = 1'b1;
          endcase
        end
      end
      StLit: begin
        // Drop the literal once the limit is hit, else emit when the slot frees
        if (status_i.at_limit) begin
          ctrl_o.set_ovf    = 1'b1;
          ctrl_o.shift_flag = 1'b1;
        end else if (status_i.out_free) begin
          ctrl_o.emit_lit   = 1'b1;
          ctrl_o.shift_flag = 1'b1;
        end
      end
      StSum: begin
        ctrl_o.emit_sum = status_i.out_free;
      end
      StRd: begin
        if (status_i.at_limit) begin
          ctrl_o.set_ovf   = 1'b1;
          ctrl_o.end_match = 1'b1;
        end else begin
          ctrl_o.rd_en = 1'b1;
        end
      end
      StWr: begin
        if (status_i.out_free) begin
          ctrl_o.emit_copy = 1'b1;
          ctrl_o.end_match = status_i.rem_one;
        end
      end
      default: ctrl_o = '0;
    endcase
  end

  // Input is taken only in idle
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == StIdle))
    else $error("ready outside idle");

  // Every match read is followed by its write step
  a_rd_then_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.rd_en |=> (state_q == StWr))
    else $error("read without write step");

  // A match starts its copy in the read step
  a_match_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load_match |=> (state_q == StRd))
    else $error("match load not followed by read");

endmodule

// ===== rtl/lzss_dp.sv =====
// Datapath for the LZSS decompressor: token state, window RAM, counters and
// output register. Depends on lzss_pkg and lzss_ram.
`timescale 1ns / 1ps

module lzss_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [7:0]                    in_byte_i,
  input  logic                          cfg_we_i,
  input  logic [lzss_pkg::CountW-1:0]   cfg_data_i,
  input  lzss_pkg::lzss_ctrl_t          ctrl_i,
  output lzss_pkg::lzss_status_t        status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lzss_pkg::OutDataW-1:0] out_data_o,
  output logic                          out_last_o,
  output logic                          out_user_o
);
  import lzss_pkg::*;

  logic [CountW-1:0]   limit_q, limit_d;
  logic [8:0]          flag_q, flag_d;
  logic                expect_q, expect_d;
  logic [7:0]          held_q, held_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [WinAddrW-1:0] wr_idx_q, wr_idx_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [WinAddrW-1:0] rd_pos_q, rd_pos_d;
  logic [LenW-1:0]     rem_q, rem_d;
  logic [7:0]          byte_q, byte_d;
  logic                rd_valid_q, rd_valid_d;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                out_last_q, out_last_d;
  logic                out_user_q, out_user_d;

  logic [7:0]          ram_rdata;
  logic [7:0]          copy_byte;
  logic [7:0]          win_wdata;
  logic                win_we;
  logic                out_free;
  logic                near_limit;
  logic [PosW-1:0]     copy_src;
  logic [WinAddrW-1:0] rd_offset;
  logic [CountW-1:0]   sum_total;

  assign out_free   = !out_valid_q || out_ready_i;
  // After this byte the next one would hit the limit
  assign near_limit = ({1'b0, count_q} + (CountW+1)'(1)) >= {1'b0, limit_q};
  assign copy_src   = {in_byte_i[7:4], held_q};
  // Entries written since start form a run beginning at StartIndex
  assign rd_offset  = rd_pos_q - StartIndex;
  assign copy_byte  = rd_valid_q ? ram_rdata : SpaceChar;
  assign win_we     = ctrl_i.emit_lit || ctrl_i.emit_copy;
  assign win_wdata  = ctrl_i.emit_lit ? byte_q : copy_byte;
  assign sum_total  = ovf_q ? '0 : count_q;

  lzss_ram #(
    .Width(8),
    .Depth(WinSize)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .waddr_i(wr_idx_q),
    .wdata_i(win_wdata),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(rd_pos_q),
    .rdata_o(ram_rdata)
  );

  // Stream state update
  always_comb begin
    limit_d    = cfg_we_i ? cfg_data_i : limit_q;
    flag_d     = flag_q;
    expect_d   = expect_q;
    held_d     = held_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    wr_idx_d   = wr_idx_q;
    fill_d     = fill_q;
    rd_pos_d   = rd_pos_q;
    rem_d      = rem_q;
    byte_d     = ctrl_i.latch_byte ? in_byte_i : byte_q;
    rd_valid_d = ctrl_i.rd_en ? ({1'b0, rd_offset} < fill_q) : rd_valid_q;

    if (ctrl_i.start) begin
      flag_d   = '0;
      expect_d = 1'b0;
      held_d   = '0;
      count_d  = '0;
      ovf_d    = 1'b0;
      wr_idx_d = StartIndex;
      fill_d   = '0;
    end
    if (ctrl_i.load_flags) begin
      flag_d = FlagMarker | {1'b0, in_byte_i};
    end
    if (ctrl_i.hold_first) begin
      held_d   = in_byte_i;
      expect_d = 1'b1;
    end
    if (ctrl_i.load_match) begin
      rd_pos_d = copy_src[WinAddrW-1:0];
      rem_d    = LenW'({1'b0, in_byte_i[3:0]}) + LenW'(Threshold + 1);
    end
    if (ctrl_i.set_ovf) begin
      ovf_d = 1'b1;
    end
    if (ctrl_i.shift_flag || ctrl_i.end_match) begin
      flag_d = flag_q >> 1;
    end
    if (ctrl_i.end_match) begin
      expect_d = 1'b0;
    end
    // Advance write pointer and counters on every decoded byte
    if (win_we) begin
      count_d  = count_q + CountW'(1);
      wr_idx_d = wr_idx_q + WinAddrW'(1);
      if (fill_q != FillW'(WinSize)) begin
        fill_d = fill_q + FillW'(1);
      end
    end
    if (ctrl_i.emit_copy) begin
      rd_pos_d = rd_pos_q + WinAddrW'(1);
      rem_d    = rem_q - LenW'(1);
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_user_d  = out_user_q;
    if (ctrl_i.emit_lit || ctrl_i.emit_copy) begin
      out_valid_d = 1'b1;
      out_data_d  = OutDataW'({1'b0, {CountW{1'b0}}, win_wdata});
      out_last_d  = ctrl_i.emit_lit || (rem_q == LenW'(1)) || near_limit;
      out_user_d  = 1'b0;
    end else if (ctrl_i.emit_sum) begin
      out_valid_d = 1'b1;
      out_data_d  = OutDataW'({ovf_q, sum_total, 8'h00});
      out_last_d  = 1'b1;
      out_user_d  = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= '1;
      flag_q      <= '0;
      expect_q    <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      wr_idx_q    <= StartIndex;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      limit_q     <= limit_d;
      flag_q      <= flag_d;
      expect_q    <= expect_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      wr_idx_q    <= wr_idx_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    held_q     <= held_d;
    rd_pos_q   <= rd_pos_d;
    rem_q      <= rem_d;
    byte_q     <= byte_d;
    rd_valid_q <= rd_valid_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_user_q <= out_user_d;
  end

  assign status_o.flag_empty    = (flag_q[8:1] == '0);
  assign status_o.lit_flag      = flag_q[0];
  assign status_o.expect_second = expect_q;
  assign status_o.ovf           = ovf_q;
  assign status_o.at_limit      = (count_q >= limit_q);
  assign status_o.rem_one       = (rem_q == LenW'(1));
  assign status_o.out_free      = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;
  assign out_user_o  = out_user_q;

  // No decoded byte once overflow is set
  a_no_emit_after_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.emit_lit || ctrl_i.emit_copy) |-> !ovf_q)
    else $error("byte emitted after overflow");

  // A result is loaded only into a free output slot
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.emit_lit || ctrl_i.emit_copy || ctrl_i.emit_sum) |-> out_free)
    else $error("output register overwritten");

  // Fill count never passes the window size
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WinSize))
    else $error("fill count out of range");

  // Overflow is sticky until a new stream starts
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && !ctrl_i.start) |=> ovf_q)
    else $error("overflow flag dropped");

  // A copy step always has bytes left
  a_copy_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit_copy |-> (rem_q != '0))
    else $error("copy with no bytes left");

endmodule
